/* design/lphm_pkg.sv */
// Shared constants, codes and beat types of the linear probing hash map.
package lphm_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int HASH_SHIFT  = 32;

    localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_SET    = 1'b1;

    localparam logic [2:0] ST_HIT      = 3'd0;
    localparam logic [2:0] ST_MISS     = 3'd1;
    localparam logic [2:0] ST_INSERTED = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic        command;
        logic [63:0] key;
        logic [63:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
    } t_rsp;

    // classified command as handed from the front end to the probe engine
    typedef struct packed {
        logic              command;
        logic              zero;
        logic [ADDR_W-1:0] slot;
        logic [63:0]       key;
        logic [63:0]       value;
    } t_qent;

endpackage

/* design/lphm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module lphm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lphm_front.sv */
// Front end: accepts command beats, hashes the key and flags zero key or value.
module lphm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lphm_pkg::t_req       i_in_data,
    input  logic                 i_clr_busy,
    input  logic                 i_q_full,
    output logic                 o_q_push,
    output lphm_pkg::t_qent      o_q_data
);

    localparam int HW = lphm_pkg::HASH_SHIFT;

    logic          r_s1_valid;
    logic          n_s1_valid;
    logic          r_cmd;
    logic          r_zero;
    logic [63:0]   r_key;
    logic [63:0]   r_value;
    logic [63:0]   r_pll;
    logic [HW-1:0] r_c1;
    logic [HW-1:0] r_c2;

    logic          w_accept;
    logic [HW-1:0] w_kl;
    logic [HW-1:0] w_kh;
    logic [HW-1:0] w_ml;
    logic [HW-1:0] w_mh;
    logic [63:0]   w_pll;
    logic [HW-1:0] w_c1;
    logic [HW-1:0] w_c2;
    logic [HW-1:0] w_phi;
    logic          w_zero;

    // key * mult mod 2^64 from 32-bit partial products; cross terms keep low half
    assign w_kl  = i_in_data.key[HW-1:0];
    assign w_kh  = i_in_data.key[63:HW];
    assign w_ml  = lphm_pkg::HASH_MULT[HW-1:0];
    assign w_mh  = lphm_pkg::HASH_MULT[63:HW];
    assign w_pll = 64'(w_kl) * 64'(w_ml);
    assign w_c1  = w_kh * w_ml;
    assign w_c2  = w_kl * w_mh;

    assign w_zero = (i_in_data.key == 64'd0)
                 || ((i_in_data.command == lphm_pkg::CMD_SET) && (i_in_data.value == 64'd0));

    assign o_q_push   = r_s1_valid && !i_q_full;
    assign o_in_ready = !i_clr_busy && (!r_s1_valid || o_q_push);
    assign w_accept   = i_in_valid && o_in_ready;

    // upper word of the product; the hash folds it onto the lower word
    assign w_phi = r_pll[63:HW] + r_c1 + r_c2;

    always_comb begin
        o_q_data.command = r_cmd;
        o_q_data.zero    = r_zero;
        o_q_data.slot    = r_pll[lphm_pkg::ADDR_W-1:0] ^ w_phi[lphm_pkg::ADDR_W-1:0];
        o_q_data.key     = r_key;
        o_q_data.value   = r_value;
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (o_q_push) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_in_data.command;
            r_zero  <= w_zero;
            r_key   <= i_in_data.key;
            r_value <= i_in_data.value;
            r_pll   <= w_pll;
            r_c1    <= w_c1;
            r_c2    <= w_c2;
        end
    end

endmodule

/* design/lphm_fifo.sv */
// Short command queue between the front end and the probe engine.
module lphm_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lphm_pkg::t_qent  i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output lphm_pkg::t_qent  o_head
);

    localparam int PTR_W = $clog2(lphm_pkg::QUEUE_DEPTH);

    lphm_pkg::t_qent r_mem [lphm_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [PTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(lphm_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(lphm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(lphm_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* design/lphm_back.sv */
// Probe engine: clears the key store, walks slots, updates the stores, drives results.
module lphm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  lphm_pkg::t_qent  i_q_head,
    output logic             o_q_pop,
    output logic             o_clr_busy,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output lphm_pkg::t_rsp   o_out_data
);

    localparam int AW = lphm_pkg::ADDR_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_CMP   = 2'd2;
    localparam logic [1:0] S_VAL   = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    logic [AW-1:0]             r_slot;
    logic [AW-1:0]             n_slot;
    logic [AW-1:0]             r_probe;
    logic [AW-1:0]             n_probe;
    logic [lphm_pkg::CNT_W-1:0] r_count;
    logic [lphm_pkg::CNT_W-1:0] n_count;
    logic                      r_cmd;
    logic                      n_cmd;
    logic [63:0]               r_key;
    logic [63:0]               n_key;
    logic [63:0]               r_value;
    logic [63:0]               n_value;
    logic                      r_out_valid;
    logic                      n_out_valid;
    lphm_pkg::t_rsp            r_out;
    lphm_pkg::t_rsp            n_out;

    logic        w_key_we;
    logic [63:0] w_key_wdata;
    logic [63:0] w_key_rdata;
    logic        w_val_we;
    logic [63:0] w_val_rdata;
    logic        w_full;

    assign w_full = (r_count >= lphm_pkg::CNT_W'(lphm_pkg::CAPACITY / 2));

    always_comb begin
        n_state     = r_state;
        n_slot      = r_slot;
        n_probe     = r_probe;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        w_key_we    = 1'b0;
        w_key_wdata = r_key;
        w_val_we    = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_key_we    = 1'b1;
                w_key_wdata = 64'd0;
                n_slot      = r_slot + 1'b1;
                if (r_slot == {AW{1'b1}}) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // take a command only with the result register empty
                if (!i_q_empty && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head.command;
                    n_key   = i_q_head.key;
                    n_value = i_q_head.value;
                    n_slot  = i_q_head.slot;
                    n_probe = '0;
                    if (i_q_head.zero) begin
                        n_out_valid = 1'b1;
                        n_out       = '{status: lphm_pkg::ST_ZERO, read_value: 64'd0};
                    end else begin
                        n_state = S_CMP;
                    end
                end
            end
            S_CMP: begin
                if (w_key_rdata == r_key) begin
                    if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                        n_state = S_VAL;
                    end else begin
                        w_val_we    = 1'b1;
                        n_out_valid = 1'b1;
                        n_out       = '{status: lphm_pkg::ST_HIT, read_value: 64'd0};
                        n_state     = S_IDLE;
                    end
                end else if (w_key_rdata == 64'd0) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                        n_out = '{status: lphm_pkg::ST_MISS, read_value: 64'd0};
                    end else if (w_full) begin
                        n_out = '{status: lphm_pkg::ST_FULL, read_value: 64'd0};
                    end else begin
                        w_key_we = 1'b1;
                        w_val_we = 1'b1;
                        n_count  = r_count + 1'b1;
                        n_out    = '{status: lphm_pkg::ST_INSERTED, read_value: 64'd0};
                    end
                end else if (r_probe == {AW{1'b1}}) begin
                    // every slot visited without a match or a hole
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_cmd == lphm_pkg::CMD_LOOKUP) begin
                        n_out = '{status: lphm_pkg::ST_MISS, read_value: 64'd0};
                    end else begin
                        n_out = '{status: lphm_pkg::ST_FULL, read_value: 64'd0};
                    end
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_probe = r_probe + 1'b1;
                end
            end
            S_VAL: begin
                n_out_valid = 1'b1;
                n_out       = '{status: lphm_pkg::ST_HIT, read_value: w_val_rdata};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_slot      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_out   <= n_out;
    end

    // key read follows the next slot so its data lines up with the compare state
    lphm_ram #(
        .WIDTH (64),
        .DEPTH (lphm_pkg::CAPACITY)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_slot),
        .i_wdata (w_key_wdata),
        .i_raddr (n_slot),
        .o_rdata (w_key_rdata)
    );

    lphm_ram #(
        .WIDTH (64),
        .DEPTH (lphm_pkg::CAPACITY)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_slot),
        .i_wdata (r_value),
        .i_raddr (r_slot),
        .o_rdata (w_val_rdata)
    );

    assign o_clr_busy  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/linear_probe_hash_map.sv */
// Top level of the linear probing hash map: front end, command queue, probe engine.
//
// Fixed-capacity hash table (lphm_pkg::CAPACITY slots, 1024 as shipped) of 64-bit
// keys and values with open addressing and linear probing; key zero marks an empty
// slot. After reset the key store is swept clear, one slot per cycle, and o_in_ready
// stays low until the sweep is done. A command beat is hashed in the front end (key
// times the mixing constant over three 32-bit multipliers, folded high word onto low
// word) and queued; the front end keeps taking beats while the queue has room. The
// probe engine takes one command at a time, and only while the result register is
// empty: it pops the command, then probes one slot after another, then reads the
// value on a lookup hit. A command with a zero key (or a set with a zero value) gets
// its result straight from the pop, without a probe. The key RAM read port sets the
// pace of the probing. Sets of new keys are refused with FULL once half the slots
// are in use.
module linear_probe_hash_map (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  lphm_pkg::t_req  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output lphm_pkg::t_rsp  o_out_data
);

    logic            w_clr_busy;
    logic            w_q_push;
    logic            w_q_pop;
    logic            w_q_full;
    logic            w_q_empty;
    lphm_pkg::t_qent w_q_in;
    lphm_pkg::t_qent w_q_head;

    // hash and classify
    lphm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_clr_busy (w_clr_busy),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    // decouples the front end from probe stalls
    lphm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // probe, update, answer
    lphm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_q_pop     (w_q_pop),
        .o_clr_busy  (w_clr_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/lphm_chk.sv */
// Port-level checker for the linear probing hash map, bound to the top level.
module lphm_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_ready,
    input lphm_pkg::t_req  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input lphm_pkg::t_rsp  o_out_data
);

    // a result beat waiting for the sink holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // right after reset: no result, and the key store sweep blocks input
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("activity during reset or key store clear");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= lphm_pkg::ST_ZERO)
        else $error("status code out of range");

    // only a hit can carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != lphm_pkg::ST_HIT
            |-> o_out_data.read_value == 64'd0)
        else $error("nonzero read value on a non-hit result");

endmodule

bind linear_probe_hash_map lphm_chk u_lphm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the linear probing hash map: directed and random command beats.
module tb_top;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 4;
    // Timeout: covers the clear sweep plus ~660 beats with a generous margin.
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_BEATS  = 640;
    localparam int SETTLE_CYCLES = 64;
    localparam int IDLE_PCT      = 24;

    // Mirror of the table: predicts the response of each accepted command beat
    // and checks responses in order against it.
    class hash_map_scoreboard;
        logic [63:0] slot_keys [lphm_pkg::CAPACITY];
        logic [63:0] slot_vals [lphm_pkg::CAPACITY];
        int unsigned entries;
        logic [63:0] stored_keys [$];   // every key that made it into the table
        lphm_pkg::t_rsp expected_rsp [$];
        int unsigned results_seen;
        int unsigned errors;

        function new();
            foreach (slot_keys[i]) begin
                slot_keys[i] = '0;
                slot_vals[i] = '0;
            end
            entries      = 0;
            results_seen = 0;
            errors       = 0;
        endfunction

        // Multiply-xorshift mix, low bits pick the home slot.
        function logic [lphm_pkg::ADDR_W-1:0] home_slot(logic [63:0] key);
            logic [63:0] mix;
            mix = key * lphm_pkg::HASH_MULT;
            mix = mix ^ (mix >> lphm_pkg::HASH_SHIFT);
            return mix[lphm_pkg::ADDR_W-1:0];
        endfunction

        function void note_request(lphm_pkg::t_req beat);
            lphm_pkg::t_rsp              rsp;
            logic [lphm_pkg::ADDR_W-1:0] slot;
            bit                          found;
            bit                          empty_seen;
            int                          n;
            rsp.status     = lphm_pkg::ST_ZERO;
            rsp.read_value = '0;
            found          = 1'b0;
            empty_seen     = 1'b0;
            if (beat.key != '0
                    && !(beat.command == lphm_pkg::CMD_SET && beat.value == '0)) begin
                slot = home_slot(beat.key);
                for (n = 0; n < lphm_pkg::CAPACITY; n++) begin
                    if (slot_keys[slot] == beat.key) begin
                        found = 1'b1;
                        break;
                    end
                    if (slot_keys[slot] == '0) begin
                        empty_seen = 1'b1;
                        break;
                    end
                    slot = slot + 1'b1;     // wraps at the top of the table
                end
                if (beat.command == lphm_pkg::CMD_LOOKUP) begin
                    if (found) begin
                        rsp.status     = lphm_pkg::ST_HIT;
                        rsp.read_value = slot_vals[slot];
                    end else begin
                        rsp.status = lphm_pkg::ST_MISS;
                    end
                end else if (found) begin
                    slot_vals[slot] = beat.value;
                    rsp.status      = lphm_pkg::ST_HIT;
                end else if (!empty_seen || 2 * entries >= lphm_pkg::CAPACITY) begin
                    rsp.status = lphm_pkg::ST_FULL;
                end else begin
                    slot_keys[slot] = beat.key;
                    slot_vals[slot] = beat.value;
                    entries++;
                    stored_keys.push_back(beat.key);
                    rsp.status = lphm_pkg::ST_INSERTED;
                end
            end
            expected_rsp.push_back(rsp);
        endfunction

        task report_mismatch(string what);
            $display("mismatch on result %0d: %s", results_seen, what);
            errors++;
        endtask

        task check_response(lphm_pkg::t_rsp got);
            lphm_pkg::t_rsp want;
            if (expected_rsp.size() == 0) begin
                report_mismatch($sformatf("no response pending, got status %0d value %h",
                                          got.status, got.read_value));
            end else begin
                want = expected_rsp.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
                if (got.read_value !== want.read_value)
                    report_mismatch($sformatf("read_value %h, want %h",
                                              got.read_value, want.read_value));
            end
            results_seen++;
        endtask
    endclass

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_ready;
    lphm_pkg::t_req i_in_data;
    logic           o_out_valid;
    logic           i_out_ready;
    lphm_pkg::t_rsp o_out_data;

    bit                 calm = 1'b0;    // both sides stop idling while set
    int unsigned        cycle_count = 0;
    hash_map_scoreboard sb;

    linear_probe_hash_map DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Timeout guard; also catches a hang in the post-reset clear sweep.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Response side: random backpressure, changed on the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Response beats are checked at the rising edge they are taken on.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready === 1'b1)
            sb.check_response(o_out_data);
    end

    function automatic logic [63:0] nonzero_word();
        logic [63:0] w;
        do w = {$urandom, $urandom}; while (w == '0);
        return w;
    endfunction

    // Random key whose probe chain starts at the given slot (about CAPACITY tries).
    function automatic logic [63:0] key_for_slot(logic [lphm_pkg::ADDR_W-1:0] slot);
        logic [63:0] k;
        do k = nonzero_word(); while (sb.home_slot(k) != slot);
        return k;
    endfunction

    function automatic logic [63:0] stored_key();
        if (sb.stored_keys.size() == 0)
            return nonzero_word();
        return sb.stored_keys[$urandom_range(sb.stored_keys.size() - 1)];
    endfunction

    function automatic lphm_pkg::t_req make_beat(logic cmd, logic [63:0] key,
                                                 logic [63:0] value);
        lphm_pkg::t_req beat;
        beat.command = cmd;
        beat.key     = key;
        beat.value   = value;
        return beat;
    endfunction

    // Mostly fresh inserts until the table hits half load, then a mix heavy on
    // refused inserts, updates and lookups against a crowded table.
    function automatic lphm_pkg::t_req random_beat();
        lphm_pkg::t_req beat;
        int             pick;
        bit             loaded;
        loaded = (2 * sb.entries >= lphm_pkg::CAPACITY);
        pick   = $urandom_range(99);
        beat   = make_beat(lphm_pkg::CMD_SET, nonzero_word(), nonzero_word());
        if ((!loaded && pick < 88) || (loaded && pick < 25)) begin
            // new key; some share a home slot with a stored key to grow clusters
            if (sb.stored_keys.size() != 0 && $urandom_range(9) == 0)
                beat.key = key_for_slot(sb.home_slot(stored_key()));
        end else if (pick < (loaded ? 45 : 91)) begin
            beat.key = stored_key();
        end else if (pick < (loaded ? 75 : 95)) begin
            beat.command = lphm_pkg::CMD_LOOKUP;
            beat.key     = stored_key();
        end else if (pick < (loaded ? 90 : 97)) begin
            // absent key, half of them walking an existing chain to its end
            beat.command = lphm_pkg::CMD_LOOKUP;
            if (sb.stored_keys.size() != 0 && $urandom_range(1) == 0)
                beat.key = key_for_slot(sb.home_slot(stored_key()));
        end else begin
            case ($urandom_range(3))
                0: begin
                    beat.command = lphm_pkg::CMD_LOOKUP;
                    beat.key     = '0;
                end
                1: beat.key = '0;
                2: begin
                    beat.key   = stored_key();
                    beat.value = '0;
                end
                default: beat.value = '0;
            endcase
        end
        return beat;
    endfunction

    // One command beat; valid held until taken, idle gaps before it.
    task automatic send_beat(lphm_pkg::t_req beat);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_request(beat);
    endtask

    // Drop valid and hold off until every pending response is back.
    task automatic drain_responses();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] wrap_keys [4];
        sb          = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero key / zero value refusals
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, '0, '1));
        send_beat(make_beat(lphm_pkg::CMD_SET, '0, 64'd1));
        send_beat(make_beat(lphm_pkg::CMD_SET, 64'd1, '0));
        send_beat(make_beat(lphm_pkg::CMD_SET, '0, '0));
        // extremes: miss on the empty table, insert, hit, update
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, '1, '0));
        send_beat(make_beat(lphm_pkg::CMD_SET, '1, '1));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, '1, '0));
        send_beat(make_beat(lphm_pkg::CMD_SET, 64'd1, 64'd1));
        send_beat(make_beat(lphm_pkg::CMD_SET, '1, 64'h8000_0000_0000_0000));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, '1, '0));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, 64'd1, '1));
        send_beat(make_beat(lphm_pkg::CMD_SET, 64'h8000_0000_0000_0000,
                            64'h7fff_ffff_ffff_ffff));

        // chain homed in the last slot: probing wraps around to slot 0
        foreach (wrap_keys[i])
            wrap_keys[i] = key_for_slot(lphm_pkg::ADDR_W'(lphm_pkg::CAPACITY - 1));
        for (int i = 0; i < 3; i++)
            send_beat(make_beat(lphm_pkg::CMD_SET, wrap_keys[i], nonzero_word()));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, wrap_keys[2], '0));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, wrap_keys[3], nonzero_word()));
        send_beat(make_beat(lphm_pkg::CMD_SET, wrap_keys[2], '1));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, wrap_keys[2], '0));
        send_beat(make_beat(lphm_pkg::CMD_LOOKUP, wrap_keys[0], '0));
        drain_responses();

        for (int i = 0; i < RANDOM_BEATS; i++) begin
            calm = (i >= 300 && i < 420);
            if (i % 150 == 149)
                drain_responses();
            send_beat(random_beat());
        end
        calm = 1'b0;
        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_rsp.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* files.f */
design/lphm_pkg.sv
design/lphm_ram.sv
design/lphm_front.sv
design/lphm_fifo.sv
design/lphm_back.sv
design/linear_probe_hash_map.sv
design/lphm_chk.sv
tb/tb_top.sv
